### design/lr_pkg.sv
`timescale 1ns / 1ps

package lr_pkg;

    localparam int FIELD_W = 12;
    localparam int COLOUR_W = 8;
    localparam int PITCH_W = 13;
    localparam int ADDR_W = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd320;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [FIELD_W-1:0]  start_x;
        logic [FIELD_W-1:0]  start_y;
        logic [FIELD_W-1:0]  end_x;
        logic [FIELD_W-1:0]  end_y;
        logic [COLOUR_W-1:0] colour_index;
    } cmd_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  pixel_x;
        logic [FIELD_W-1:0]  pixel_y;
        logic [ADDR_W-1:0]   pixel_address;
        logic [COLOUR_W-1:0] pixel_colour;
        logic                last_pixel;
    } pixel_t;

    // Width of one queued line command for a given coordinate width:
    // kind, five coordinates, two direction flags and the colour.
    function automatic int cmd_entry_bits(input int cw);
        return 5 * cw + 3 + COLOUR_W;
    endfunction

endpackage

### design/lr_front.sv
`timescale 1ns / 1ps

module lr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                                            cmd_valid,
    input  lr_pkg::cmd_t                                    cmd,
    output logic                                            cmd_stall,
    input  logic                                            q_full,
    output logic                                            push,
    output logic [lr_pkg::cmd_entry_bits(COORD_BITS)-1:0]   entry
);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic                        is_advance;
        coord_t                      major_pos;
        coord_t                      major_end;
        coord_t                      minor_pos;
        coord_t                      major_delta;
        coord_t                      minor_delta;
        logic                        minor_down;
        logic                        axes_swapped;
        logic [lr_pkg::COLOUR_W-1:0] colour;
    } line_cmd_t;

    coord_t    ax;
    coord_t    ay;
    coord_t    bx;
    coord_t    by;
    coord_t    dx;
    coord_t    dy;
    logic      steep;
    coord_t    p_maj;
    coord_t    p_min;
    coord_t    q_maj;
    coord_t    q_min;
    coord_t    a_maj;
    coord_t    a_min;
    coord_t    b_maj;
    coord_t    b_min;
    line_cmd_t ent;

    assign cmd_stall = q_full;
    assign push      = cmd_valid && !q_full;

    always_comb
    begin
        ax = COORD_BITS'(cmd.start_x);
        ay = COORD_BITS'(cmd.start_y);
        bx = COORD_BITS'(cmd.end_x);
        by = COORD_BITS'(cmd.end_y);
        dx = (ax > bx) ? (ax - bx) : (bx - ax);
        dy = (ay > by) ? (ay - by) : (by - ay);
        steep = dy > dx;

        // put the steeper axis on the major side
        p_maj = steep ? ay : ax;
        p_min = steep ? ax : ay;
        q_maj = steep ? by : bx;
        q_min = steep ? bx : by;

        // order endpoints so the major coordinate counts up
        if (p_maj > q_maj)
        begin
            a_maj = q_maj;
            a_min = q_min;
            b_maj = p_maj;
            b_min = p_min;
        end
        else
        begin
            a_maj = p_maj;
            a_min = p_min;
            b_maj = q_maj;
            b_min = q_min;
        end

        ent.is_advance   = (cmd.kind == lr_pkg::KIND_ADVANCE);
        ent.major_pos    = a_maj;
        ent.major_end    = b_maj;
        ent.minor_pos    = a_min;
        ent.major_delta  = b_maj - a_maj;
        ent.minor_delta  = (a_min > b_min) ? (a_min - b_min) : (b_min - a_min);
        ent.minor_down   = !(a_min < b_min);
        ent.axes_swapped = steep;
        ent.colour       = cmd.colour_index;
    end

    assign entry = ent;

endmodule

### design/lr_queue.sv
`timescale 1ns / 1ps

module lr_queue #(
    parameter int WIDTH = 71
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             valid,
    output logic [WIDTH-1:0] head_data,
    input  logic             pop
);

    localparam int DEPTH = lr_pkg::QUEUE_DEPTH;
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign valid     = (count_reg != '0);
    assign head_data = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/lr_back.sv
`timescale 1ns / 1ps

module lr_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic [lr_pkg::PITCH_W-1:0]                    line_pitch,
    input  logic                                          q_valid,
    input  logic [lr_pkg::cmd_entry_bits(COORD_BITS)-1:0] q_entry,
    output logic                                          q_pop,
    output logic                                          pix_valid,
    input  logic                                          pix_stall,
    output lr_pkg::pixel_t                                pix
);

    localparam int EW = COORD_BITS + 2;
    localparam int AW = lr_pkg::FIELD_W + lr_pkg::PITCH_W;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic                        is_advance;
        coord_t                      major_pos;
        coord_t                      major_end;
        coord_t                      minor_pos;
        coord_t                      major_delta;
        coord_t                      minor_delta;
        logic                        minor_down;
        logic                        axes_swapped;
        logic [lr_pkg::COLOUR_W-1:0] colour;
    } line_cmd_t;

    line_cmd_t                        head;
    coord_t                           major_pos_reg;
    coord_t                           major_pos_next;
    coord_t                           major_end_reg;
    coord_t                           minor_pos_reg;
    coord_t                           minor_pos_next;
    coord_t                           major_delta_reg;
    coord_t                           minor_delta_reg;
    logic                             minor_down_reg;
    logic                             axes_swapped_reg;
    logic [lr_pkg::COLOUR_W-1:0]      colour_reg;
    logic                             active_reg;
    logic                             active_next;
    logic signed [EW-1:0]             error_reg;
    logic signed [EW-1:0]             error_next;
    logic signed [EW-1:0]             err_sum;
    logic signed [EW:0]               err_twice;
    logic signed [EW:0]               major_ext;
    logic                             minor_step;
    logic                             last;
    coord_t                           px;
    coord_t                           py;
    logic [lr_pkg::FIELD_W-1:0]       pix_x;
    logic [lr_pkg::FIELD_W-1:0]       pix_y;
    logic [lr_pkg::FIELD_W+lr_pkg::PITCH_W-1:0] row_base;
    logic [lr_pkg::FIELD_W+lr_pkg::PITCH_W-1:0] addr_sum;
    logic                             out_ready;
    logic                             draw;
    logic                             out_valid_reg;
    lr_pkg::pixel_t                   out_reg;

    assign head      = q_entry;
    assign out_ready = !out_valid_reg || !pix_stall;

    // a start or a dropped advance needs no output slot
    assign q_pop = q_valid && (!head.is_advance || !active_reg || out_ready);
    assign draw  = q_pop && head.is_advance && active_reg;

    always_comb
    begin
        px   = axes_swapped_reg ? minor_pos_reg : major_pos_reg;
        py   = axes_swapped_reg ? major_pos_reg : minor_pos_reg;
        last = (major_pos_reg == major_end_reg);

        err_sum    = error_reg + $signed(EW'(minor_delta_reg));
        err_twice  = {err_sum, 1'b0};
        major_ext  = $signed((EW + 1)'(major_delta_reg));
        minor_step = (err_twice >= major_ext);

        minor_pos_next = minor_pos_reg;
        error_next     = err_sum;
        if (minor_step)
        begin
            minor_pos_next = minor_down_reg ? minor_pos_reg - 1'b1 : minor_pos_reg + 1'b1;
            error_next     = err_sum - $signed(EW'(major_delta_reg));
        end
        major_pos_next = last ? major_pos_reg : major_pos_reg + 1'b1;
        active_next    = !last;

        pix_x    = lr_pkg::FIELD_W'(px);
        pix_y    = lr_pkg::FIELD_W'(py);
        row_base = AW'(pix_y) * AW'(line_pitch);
        addr_sum = row_base + AW'(pix_x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_pos_reg    <= '0;
            major_end_reg    <= '0;
            minor_pos_reg    <= '0;
            major_delta_reg  <= '0;
            minor_delta_reg  <= '0;
            minor_down_reg   <= 1'b0;
            axes_swapped_reg <= 1'b0;
            colour_reg       <= '0;
            error_reg        <= '0;
            active_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (q_pop && !head.is_advance)
            begin
                major_pos_reg    <= head.major_pos;
                major_end_reg    <= head.major_end;
                minor_pos_reg    <= head.minor_pos;
                major_delta_reg  <= head.major_delta;
                minor_delta_reg  <= head.minor_delta;
                minor_down_reg   <= head.minor_down;
                axes_swapped_reg <= head.axes_swapped;
                colour_reg       <= head.colour;
                error_reg        <= '0;
                active_reg       <= 1'b1;
            end
            else if (draw)
            begin
                major_pos_reg <= major_pos_next;
                minor_pos_reg <= minor_pos_next;
                error_reg     <= error_next;
                active_reg    <= active_next;
            end

            if (draw)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!pix_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (draw)
        begin
            out_reg.pixel_x       <= pix_x;
            out_reg.pixel_y       <= pix_y;
            out_reg.pixel_address <= lr_pkg::ADDR_W'(addr_sum);
            out_reg.pixel_colour  <= colour_reg;
            out_reg.last_pixel    <= last;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

endmodule

### design/line_rasterizer.sv
`timescale 1ns / 1ps

// Bresenham line rasterizer for an 8-bit indexed framebuffer.
// Command channel (cmd_valid / cmd_stall / cmd): kind start loads two
// endpoints and a colour and replaces any line in progress; kind advance
// emits the next pixel of the current line, or nothing when no line is open.
// Pixel channel (pix_valid / pix_stall / pix): column, row, byte address
// row * pitch + column (low 24 bits), colour, and a flag on the final pixel.
// Pitch is written through cfg_wr_en / cfg_wr_data while the block is idle.
// An accepted item is written into a two-entry command queue; when it reaches
// the head, the back end takes it and registers its pixel for the pixel channel.
// While pix_stall is low one item per cycle is sustained: line setup is done in
// the front path on the way into the queue, and the back end updates position
// and error term and forms the address with a single 12x13 multiply each cycle.
// While pix_stall is high the pending pixel holds; starts and dropped
// advances still drain, and the queue absorbs up to two further items
// before cmd_stall rises.
// Reset clears the queue, closes any line, empties the output register and
// sets the pitch to 320.
module line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [lr_pkg::PITCH_W-1:0] cfg_wr_data,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  lr_pkg::cmd_t               cmd,
    output logic                       pix_valid,
    input  logic                       pix_stall,
    output lr_pkg::pixel_t             pix
);

    localparam int QW = lr_pkg::cmd_entry_bits(COORD_BITS);

    logic [lr_pkg::PITCH_W-1:0] line_pitch_reg;
    logic                       q_push;
    logic [QW-1:0]              q_push_data;
    logic                       q_full;
    logic                       q_valid;
    logic [QW-1:0]              q_head;
    logic                       q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_pitch_reg <= lr_pkg::PITCH_RESET;
        end
        else if (cfg_wr_en)
        begin
            line_pitch_reg <= cfg_wr_data;
        end
    end

    lr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_stall (cmd_stall),
        .q_full    (q_full),
        .push      (q_push),
        .entry     (q_push_data)
    );

    lr_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .valid     (q_valid),
        .head_data (q_head),
        .pop       (q_pop)
    );

    lr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_pitch (line_pitch_reg),
        .q_valid    (q_valid),
        .q_entry    (q_head),
        .q_pop      (q_pop),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix)
    );

`ifndef SYNTHESIS
    // the back end never takes from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command taken from empty queue");

    // a new pixel only appears after a queued command was available
    a_pixel_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_valid) |-> $past(q_valid))
        else $error("pixel emitted without a queued command");

    // with the pixel side free, a full queue frees an entry by the next cycle
    a_stall_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_stall && !pix_stall) |=> !cmd_stall)
        else $error("command stall held with free output");
`endif

endmodule

### tb/tb_line_rasterizer.sv
`timescale 1ns / 1ps

module tb_line_rasterizer;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int PRINT_CAP = 40;
    localparam int PHASE_ITEMS = 265;
    localparam logic [lr_pkg::FIELD_W-1:0] COORD_MAX = '1;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_PIXEL
    } row_check_t;

    typedef struct {
        lr_pkg::cmd_t   c;
        row_check_t     chk;
        lr_pkg::pixel_t px;
    } stim_row_t;

    typedef struct {
        logic [lr_pkg::FIELD_W-1:0]  major_pos;
        logic [lr_pkg::FIELD_W-1:0]  major_end;
        logic [lr_pkg::FIELD_W-1:0]  minor_pos;
        logic [lr_pkg::FIELD_W-1:0]  major_delta;
        logic [lr_pkg::FIELD_W-1:0]  minor_delta;
        int                          err;
        bit                          minor_down;
        bit                          swapped;
        bit                          active;
        logic [lr_pkg::COLOUR_W-1:0] colour;
    } line_state_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [lr_pkg::PITCH_W-1:0] cfg_wr_data;
    logic                       cmd_valid;
    logic                       cmd_stall;
    lr_pkg::cmd_t               cmd;
    logic                       pix_valid;
    logic                       pix_stall;
    lr_pkg::pixel_t             pix;

    line_state_t                ln;
    logic [lr_pkg::PITCH_W-1:0] pitch_model;
    lr_pkg::pixel_t             pixel_queue[$];
    int                         errors = 0;
    int                         quiet_cycles = 0;
    int                         rx_count;
    bit                         tx_fast;
    bit                         rx_fast;

    always #5 clk = ~clk;

    line_rasterizer #(
        .COORD_BITS(12)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix(pix)
    );

    function automatic logic [lr_pkg::FIELD_W-1:0] coord_gap(
        input logic [lr_pkg::FIELD_W-1:0] a,
        input logic [lr_pkg::FIELD_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Advance the line state by one item; returns 1 when a pixel comes out.
    function automatic bit bresenham_step(input lr_pkg::cmd_t c, output lr_pkg::pixel_t p);
        logic [lr_pkg::FIELD_W-1:0] a_maj;
        logic [lr_pkg::FIELD_W-1:0] a_min;
        logic [lr_pkg::FIELD_W-1:0] b_maj;
        logic [lr_pkg::FIELD_W-1:0] b_min;
        logic [lr_pkg::FIELD_W-1:0] t;
        logic [63:0]                addr;
        int                         e;
        bit                         last;
        p = '0;
        if (c.kind == lr_pkg::KIND_START)
        begin
            ln.swapped = coord_gap(c.start_y, c.end_y) > coord_gap(c.start_x, c.end_x);
            if (ln.swapped)
            begin
                a_maj = c.start_y;
                a_min = c.start_x;
                b_maj = c.end_y;
                b_min = c.end_x;
            end
            else
            begin
                a_maj = c.start_x;
                a_min = c.start_y;
                b_maj = c.end_x;
                b_min = c.end_y;
            end
            if (a_maj > b_maj)
            begin
                t = a_maj;
                a_maj = b_maj;
                b_maj = t;
                t = a_min;
                a_min = b_min;
                b_min = t;
            end
            ln.major_pos = a_maj;
            ln.major_end = b_maj;
            ln.minor_pos = a_min;
            ln.major_delta = b_maj - a_maj;
            ln.minor_delta = coord_gap(a_min, b_min);
            ln.minor_down = !(a_min < b_min);
            ln.err = 0;
            ln.colour = c.colour_index;
            ln.active = 1'b1;
            return 1'b0;
        end
        if (!ln.active)
        begin
            return 1'b0;
        end
        p.pixel_x = ln.swapped ? ln.minor_pos : ln.major_pos;
        p.pixel_y = ln.swapped ? ln.major_pos : ln.minor_pos;
        last = (ln.major_pos == ln.major_end);
        addr = 64'(p.pixel_y) * 64'(pitch_model) + 64'(p.pixel_x);
        p.pixel_address = addr[lr_pkg::ADDR_W-1:0];
        p.pixel_colour = ln.colour;
        p.last_pixel = last;
        e = ln.err + int'(ln.minor_delta);
        if (2 * e >= int'(ln.major_delta))
        begin
            ln.minor_pos = ln.minor_down ? ln.minor_pos - 1'b1 : ln.minor_pos + 1'b1;
            e = e - int'(ln.major_delta);
        end
        ln.err = e;
        if (last)
        begin
            ln.active = 1'b0;
        end
        else
        begin
            ln.major_pos = ln.major_pos + 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic lr_pkg::cmd_t make_cmd(input logic kind, input int sx, input int sy,
                                              input int ex, input int ey, input int col);
        lr_pkg::cmd_t c;
        c.kind = kind;
        c.start_x = sx[lr_pkg::FIELD_W-1:0];
        c.start_y = sy[lr_pkg::FIELD_W-1:0];
        c.end_x = ex[lr_pkg::FIELD_W-1:0];
        c.end_y = ey[lr_pkg::FIELD_W-1:0];
        c.colour_index = col[lr_pkg::COLOUR_W-1:0];
        return c;
    endfunction

    function automatic lr_pkg::cmd_t random_cmd();
        return make_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 255));
    endfunction

    // Lean on the edges of the coordinate range now and then.
    function automatic logic [lr_pkg::FIELD_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
        begin
            return '0;
        end
        else if (r == 1)
        begin
            return COORD_MAX;
        end
        return lr_pkg::FIELD_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [lr_pkg::FIELD_W-1:0] offset_coord(
        input logic [lr_pkg::FIELD_W-1:0] base,
        input int reach);
        int off;
        int v;
        off = $urandom_range(0, reach);
        v = $urandom_range(0, 1) ? int'(base) + off : int'(base) - off;
        if (v > 4095)
        begin
            v = int'(base) - off;
        end
        if (v < 0)
        begin
            v = int'(base) + off;
        end
        return v[lr_pkg::FIELD_W-1:0];
    endfunction

    task automatic report(input string msg);
        errors++;
        if (errors <= PRINT_CAP)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic check_pixel(input lr_pkg::pixel_t got);
        lr_pkg::pixel_t want;
        if (pixel_queue.size() == 0)
        begin
            report($sformatf("pixel x=%0d y=%0d with none pending", got.pixel_x, got.pixel_y));
        end
        else
        begin
            want = pixel_queue.pop_front();
            if (got.pixel_x !== want.pixel_x)
                report($sformatf("pixel_x %0d, want %0d", got.pixel_x, want.pixel_x));
            if (got.pixel_y !== want.pixel_y)
                report($sformatf("pixel_y %0d, want %0d", got.pixel_y, want.pixel_y));
            if (got.pixel_address !== want.pixel_address)
                report($sformatf("pixel_address %0d, want %0d",
                                 got.pixel_address, want.pixel_address));
            if (got.pixel_colour !== want.pixel_colour)
                report($sformatf("pixel_colour %0h, want %0h",
                                 got.pixel_colour, want.pixel_colour));
            if (got.last_pixel !== want.last_pixel)
                report($sformatf("last_pixel %0b, want %0b", got.last_pixel, want.last_pixel));
        end
    endtask

    // Offer one item, hold it until accepted, then update the line state.
    task automatic send_cmd(input lr_pkg::cmd_t c, output bit has_pix,
                            output lr_pkg::pixel_t p);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (cmd_stall !== 1'b0);
        has_pix = bresenham_step(c, p);
    endtask

    task automatic drain_pixels();
        cmd_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_pitch(input logic [lr_pkg::PITCH_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pitch_model = value;
    endtask

    task automatic send_counted(input lr_pkg::cmd_t c, inout int done);
        bit             counted;
        bit             got;
        lr_pkg::pixel_t p;
        counted = (c.kind == lr_pkg::KIND_START) || ln.active;
        send_cmd(c, got, p);
        if (got)
        begin
            pixel_queue.push_back(p);
        end
        if (counted)
        begin
            done++;
        end
    endtask

    // Mostly whole lines with random content; the rest cut short, overrun or noise.
    task automatic run_random(input int budget);
        int           done;
        int           reach;
        int           n_adv;
        lr_pkg::cmd_t c;
        done = 0;
        while (done < budget)
        begin
            tx_fast = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 6) != 0)
            begin
                c = random_cmd();
                c.kind = lr_pkg::KIND_START;
                c.start_x = pick_coord();
                c.start_y = pick_coord();
                if ($urandom_range(0, 15) == 0)
                begin
                    c.end_x = pick_coord();
                    c.end_y = pick_coord();
                end
                else
                begin
                    reach = $urandom_range(0, 24);
                    c.end_x = offset_coord(c.start_x, reach);
                    c.end_y = offset_coord(c.start_y, reach);
                end
                n_adv = int'(coord_gap(c.start_x, c.end_x));
                if (int'(coord_gap(c.start_y, c.end_y)) > n_adv)
                    n_adv = int'(coord_gap(c.start_y, c.end_y));
                n_adv = n_adv + 1;
                if (n_adv > 64 && $urandom_range(0, 9) != 0)
                    n_adv = $urandom_range(1, 64);
                case ($urandom_range(0, 7))
                    0: n_adv = $urandom_range(0, n_adv);
                    1: n_adv = n_adv + $urandom_range(1, 3);
                    default: ;
                endcase
                // keep the phase close to its item budget
                if (n_adv > budget - done)
                    n_adv = budget - done;
                send_counted(c, done);
                repeat (n_adv)
                begin
                    c = random_cmd();
                    c.kind = lr_pkg::KIND_ADVANCE;
                    send_counted(c, done);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_counted(random_cmd(), done);
                end
            end
        end
    endtask

    // Pixel side: random stall per item, long hold-offs at two points.
    initial
    begin
        int n;
        pix_stall = 1'b0;
        rx_count = 0;
        rx_fast = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_count % 64 == 0)
            begin
                rx_fast = ($urandom_range(0, 3) == 0);
            end
            if (rx_count == 150 || rx_count == 900)
            begin
                n = HOLD_CYCLES;
            end
            else
            begin
                n = rx_fast ? 0 : $urandom_range(0, 11);
            end
            if (n > 0)
            begin
                pix_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            pix_stall <= 1'b0;
            do @(posedge clk); while (pix_valid !== 1'b1);
            check_pixel(pix);
            rx_count++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (cmd_valid === 1'b1 && cmd_stall === 1'b0)
                || (pix_valid === 1'b1 && pix_stall === 1'b0))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[line_rasterizer] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t                  rows[$];
        logic [lr_pkg::PITCH_W-1:0] pitches[$];
        bit                         got;
        lr_pkg::pixel_t             p;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        cmd_valid = 1'b0;
        cmd = '0;
        tx_fast = 1'b0;
        ln = '{default: 0};
        pitch_model = lr_pkg::PITCH_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Advance while idle, then single point lines at both corners.
        rows.push_back('{make_cmd(lr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0), CHK_NONE, '0});
        rows.push_back('{make_cmd(lr_pkg::KIND_START, 0, 0, 0, 0, 8'hFF), CHK_NONE, '0});
        rows.push_back('{make_cmd(lr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0), CHK_PIXEL,
                         lr_pkg::pixel_t'{12'd0, 12'd0, 24'd0, 8'hFF, 1'b1}});
        rows.push_back('{make_cmd(lr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0), CHK_NONE, '0});
        rows.push_back('{make_cmd(lr_pkg::KIND_START, 4095, 4095, 4095, 4095, 0),
                         CHK_NONE, '0});
        rows.push_back('{make_cmd(lr_pkg::KIND_ADVANCE, 4095, 4095, 4095, 4095, 255),
                         CHK_PIXEL,
                         lr_pkg::pixel_t'{12'd4095, 12'd4095, 24'd1314495, 8'h00, 1'b1}});
        // Full width, reversed diagonal, steep, vertical, falling minor axis.
        rows.push_back('{make_cmd(lr_pkg::KIND_START, 0, 0, 4095, 0, 8'hA5), CHK_MODEL, '0});
        repeat (2)
            rows.push_back('{make_cmd(lr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0), CHK_MODEL, '0});
        rows.push_back('{make_cmd(lr_pkg::KIND_START, 4095, 0, 0, 4095, 8'h5A),
                         CHK_MODEL, '0});
        repeat (2)
            rows.push_back('{make_cmd(lr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0), CHK_MODEL, '0});
        rows.push_back('{make_cmd(lr_pkg::KIND_START, 10, 0, 12, 4095, 8'h3C),
                         CHK_MODEL, '0});
        repeat (2)
            rows.push_back('{make_cmd(lr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0), CHK_MODEL, '0});
        rows.push_back('{make_cmd(lr_pkg::KIND_START, 100, 50, 100, 40, 8'hC3),
                         CHK_MODEL, '0});
        repeat (2)
            rows.push_back('{make_cmd(lr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0), CHK_MODEL, '0});
        rows.push_back('{make_cmd(lr_pkg::KIND_START, 0, 4095, 4095, 4094, 8'h81),
                         CHK_MODEL, '0});
        repeat (2)
            rows.push_back('{make_cmd(lr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0), CHK_MODEL, '0});
        // Replace the open line, run it out, then one advance past its end.
        rows.push_back('{make_cmd(lr_pkg::KIND_START, 5, 5, 7, 7, 8'h7E), CHK_MODEL, '0});
        repeat (4)
            rows.push_back('{make_cmd(lr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0), CHK_MODEL, '0});

        foreach (rows[i])
        begin
            send_cmd(rows[i].c, got, p);
            case (rows[i].chk)
                CHK_MODEL: if (got) pixel_queue.push_back(p);
                CHK_PIXEL: pixel_queue.push_back(rows[i].px);
                default: ;
            endcase
        end
        drain_pixels();

        pitches = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd640,
                    lr_pkg::PITCH_W'($urandom_range(1, 4096)),
                    lr_pkg::PITCH_W'($urandom_range(1, 4096))};
        foreach (pitches[i])
        begin
            write_pitch(pitches[i]);
            run_random(PHASE_ITEMS);
            drain_pixels();
        end

        if (errors == 0)
        begin
            $display("[line_rasterizer] OK");
        end
        else
        begin
            $display("[line_rasterizer] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
design/lr_pkg.sv
design/lr_front.sv
design/lr_queue.sv
design/lr_back.sv
design/line_rasterizer.sv
tb/tb_line_rasterizer.sv
